// ----- design/hfdm_pkg.sv -----
// Shared constants and types for the hysteresis frequency and duty meter.
// Used by the front, queue, back and checker files; no dependencies.
package hfdm_pkg;

   // parameter defaults
   localparam int unsigned MAX_SAMPLES_DEF = 65536;
   localparam int unsigned SAMPLE_BITS_DEF = 16;

   // field widths
   localparam int unsigned SAMP_W    = 16;
   localparam int unsigned ELAPSED_W = 32;
   localparam int unsigned FREQ_W    = 35;
   localparam int unsigned DUTY_W    = 14;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 16;

   // stream packing
   localparam int unsigned REQ_DATA_W = 48;  // sample, elapsed_us
   localparam int unsigned RSP_DATA_W = 88;  // freq, duty, min, max, 7 pad bits
   localparam int unsigned RSP_USER_W = 1;   // overflow

   localparam int unsigned DUTY_LSB = FREQ_W;
   localparam int unsigned MIN_LSB  = DUTY_LSB + DUTY_W;
   localparam int unsigned MAX_LSB  = MIN_LSB + SAMP_W;
   localparam int unsigned PAD_W    = RSP_DATA_W - (MAX_LSB + SAMP_W);

   // scale factors: half of 1e6 for toggles to Hz, 100*100 for hundredths of a percent
   localparam int unsigned FSCALE_W   = 19;
   localparam logic [FSCALE_W-1:0] FREQ_SCALE = 19'd500000;
   localparam logic [DUTY_W-1:0]   DUTY_SCALE = 14'd10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESH = 1'b1;

   localparam logic [CSR_DAT_W-1:0] LOW_THRESH_RST  = 16'h0000;
   localparam logic [CSR_DAT_W-1:0] HIGH_THRESH_RST = 16'hFFFF;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

endpackage

// ----- design/hfdm_front.sv -----
// Front end: hysteresis comparator, saturating counters and min/max tracking.
// Pushes one finished capture record into the queue on the last sample. Uses hfdm_pkg.
module hfdm_front #(
   parameter int unsigned MAX_SAMPLES = 65536,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned CW          = 17,
   parameter int unsigned JOB_W       = 116
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hfdm_pkg::SAMP_W-1:0]       req_sample,
   input  logic [hfdm_pkg::ELAPSED_W-1:0]    req_elapsed_us,
   input  logic                              req_tlast,
   input  logic                              csr_we,
   input  logic [hfdm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hfdm_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  hfdm_pkg::q_flags_type             q_flags,
   output logic                              q_push,
   output logic [JOB_W-1:0]                  q_wdata
);
   import hfdm_pkg::*;

   localparam int unsigned SW = (SAMPLE_BITS < SAMP_W) ? SAMPLE_BITS : SAMP_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

   logic [CSR_DAT_W-1:0] low_th_ff, high_th_ff;
   logic                 lvl_ff, lvl_in, lvl_up;
   logic [CW-1:0]        tog_ff, tog_in, tog_up;
   logic [CW-1:0]        high_ff, high_in, high_up;
   logic [CW-1:0]        cnt_ff, cnt_in, cnt_up;
   logic [SAMP_W-1:0]    min_ff, min_in, min_up;
   logic [SAMP_W-1:0]    max_ff, max_in, max_up;
   logic                 sat_ff, sat_in, sat_up;
   logic [SAMP_W-1:0]    smp;
   logic                 accept;
   logic                 toggle;

   assign req_tready = !q_flags.full;
   assign accept     = req_tvalid && req_tready;
   assign smp        = SAMP_W'(req_sample[SW-1:0]);

   always_comb begin
      if (cnt_ff == '0) begin
         min_up = smp;
         max_up = smp;
      end else begin
         min_up = (smp < min_ff) ? smp : min_ff;
         max_up = (smp > max_ff) ? smp : max_ff;
      end

      toggle = 1'b0;
      lvl_up = lvl_ff;
      if (lvl_ff && (smp < low_th_ff)) begin
         lvl_up = 1'b0;
         toggle = 1'b1;
      end else if (!lvl_ff && (smp > high_th_ff)) begin
         lvl_up = 1'b1;
         toggle = 1'b1;
      end

      tog_up  = (toggle && (tog_ff < CNT_MAX)) ? tog_ff + 1'b1 : tog_ff;
      high_up = (lvl_up && (high_ff < CNT_MAX)) ? high_ff + 1'b1 : high_ff;

      if (cnt_ff >= CNT_MAX) begin
         cnt_up = cnt_ff;
         sat_up = 1'b1;
      end else begin
         cnt_up = cnt_ff + 1'b1;
         sat_up = sat_ff;
      end

      // hold when idle, clear after the last sample
      lvl_in  = lvl_ff;
      tog_in  = tog_ff;
      high_in = high_ff;
      cnt_in  = cnt_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      sat_in  = sat_ff;
      if (accept) begin
         if (req_tlast) begin
            lvl_in  = 1'b0;
            tog_in  = '0;
            high_in = '0;
            cnt_in  = '0;
            min_in  = '0;
            max_in  = '0;
            sat_in  = 1'b0;
         end else begin
            lvl_in  = lvl_up;
            tog_in  = tog_up;
            high_in = high_up;
            cnt_in  = cnt_up;
            min_in  = min_up;
            max_in  = max_up;
            sat_in  = sat_up;
         end
      end
   end

   assign q_push  = accept && req_tlast;
   assign q_wdata = {sat_up, max_up, min_up, cnt_up, high_up, tog_up, req_elapsed_us};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_th_ff  <= LOW_THRESH_RST;
         high_th_ff <= HIGH_THRESH_RST;
         lvl_ff     <= 1'b0;
         tog_ff     <= '0;
         high_ff    <= '0;
         cnt_ff     <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         sat_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOW_THRESH:  low_th_ff  <= csr_wdata;
               CSR_HIGH_THRESH: high_th_ff <= csr_wdata;
               default: ;
            endcase
         end
         lvl_ff  <= lvl_in;
         tog_ff  <= tog_in;
         high_ff <= high_in;
         cnt_ff  <= cnt_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         sat_ff  <= sat_in;
      end
   end

endmodule

// ----- design/hfdm_queue.sv -----
// Small FIFO of capture records between the front and the back end.
// Uses hfdm_pkg for depth and the flag struct.
module hfdm_queue #(
   parameter int unsigned JOB_W = 116
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [JOB_W-1:0]      wdata,
   input  logic                  pop,
   output logic [JOB_W-1:0]      rdata,
   output hfdm_pkg::q_flags_type flags
);
   import hfdm_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   logic [JOB_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign flags.full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign flags.empty = (cnt_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign rdata       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- design/hfdm_back.sv -----
// Back end: scales the counts, runs two restoring dividers one bit per cycle
// and holds the result in the output register. Uses hfdm_pkg.
module hfdm_back #(
   parameter int unsigned CW    = 17,
   parameter int unsigned JOB_W = 116
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hfdm_pkg::q_flags_type             q_flags,
   input  logic [JOB_W-1:0]                  q_rdata,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hfdm_pkg::FREQ_W-1:0]       rsp_frequency_hz,
   output logic [hfdm_pkg::DUTY_W-1:0]       rsp_duty_hundredths,
   output logic [hfdm_pkg::SAMP_W-1:0]       rsp_min_sample,
   output logic [hfdm_pkg::SAMP_W-1:0]       rsp_max_sample,
   output logic                              rsp_overflow
);
   import hfdm_pkg::*;

   localparam int unsigned PF_W  = CW + FSCALE_W;
   localparam int unsigned PD_W  = CW + DUTY_W;
   localparam int unsigned NUM_W = (PF_W > FREQ_W) ? PF_W : FREQ_W;
   localparam int unsigned IT_W  = $clog2(NUM_W);
   localparam logic [IT_W-1:0] IT_LAST = IT_W'(NUM_W - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;

   // record fields
   logic [ELAPSED_W-1:0] j_elapsed;
   logic [CW-1:0]        j_tog, j_high, j_cnt;
   logic [SAMP_W-1:0]    j_min, j_max;
   logic                 j_sat;

   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [CW-1:0]        tog_ff, high_ff, cnt_ff;
   logic [SAMP_W-1:0]    min_ff, max_ff;
   logic                 sat_ff;

   logic [PF_W-1:0]      prodf;
   logic [PD_W-1:0]      prodd;
   logic [NUM_W-1:0]     numf_ff, numf_in, numd_ff, numd_in;
   logic [NUM_W-1:0]     quof_ff, quof_in, quod_ff, quod_in;
   logic [ELAPSED_W:0]   remf_ff, remf_in, remf_sh;
   logic [CW:0]          remd_ff, remd_in, remd_sh;
   logic [IT_W-1:0]      it_ff, it_in;
   logic                 qf_bit, qd_bit;

   logic                 valid_ff, valid_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [DUTY_W-1:0]    duty_ff, duty_in;

   assign {j_sat, j_max, j_min, j_cnt, j_high, j_tog, j_elapsed} = q_rdata;

   assign prodf = PF_W'(tog_ff) * PF_W'(FREQ_SCALE);
   assign prodd = PD_W'(high_ff) * PD_W'(DUTY_SCALE);

   assign q_pop = (state_ff == ST_IDLE) && !q_flags.empty;

   // one restoring step for each divider
   always_comb begin
      remf_sh = {remf_ff[ELAPSED_W-1:0], numf_ff[NUM_W-1]};
      qf_bit  = (remf_sh >= {1'b0, elapsed_ff});
      remd_sh = {remd_ff[CW-1:0], numd_ff[NUM_W-1]};
      qd_bit  = (remd_sh >= {1'b0, cnt_ff});
   end

   always_comb begin
      state_in = state_ff;
      numf_in  = numf_ff;
      numd_in  = numd_ff;
      quof_in  = quof_ff;
      quod_in  = quod_ff;
      remf_in  = remf_ff;
      remd_in  = remd_ff;
      it_in    = it_ff;
      valid_in = valid_ff;
      freq_in  = freq_ff;
      duty_in  = duty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_flags.empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            numf_in  = NUM_W'(prodf);
            numd_in  = NUM_W'(prodd);
            quof_in  = '0;
            quod_in  = '0;
            remf_in  = '0;
            remd_in  = '0;
            it_in    = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            numf_in = numf_ff << 1;
            numd_in = numd_ff << 1;
            quof_in = {quof_ff[NUM_W-2:0], qf_bit};
            quod_in = {quod_ff[NUM_W-2:0], qd_bit};
            remf_in = qf_bit ? (remf_sh - {1'b0, elapsed_ff}) : remf_sh;
            remd_in = qd_bit ? (remd_sh - {1'b0, cnt_ff}) : remd_sh;
            it_in   = it_ff + 1'b1;
            if (it_ff == IT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (elapsed_ff == '0) begin
               freq_in = '0;
            end else if ((quof_ff >> FREQ_W) != '0) begin
               freq_in = '1;
            end else begin
               freq_in = quof_ff[FREQ_W-1:0];
            end
            duty_in  = (cnt_ff == '0) ? '0 : quod_ff[DUTY_W-1:0];
            valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         elapsed_ff <= j_elapsed;
         tog_ff     <= j_tog;
         high_ff    <= j_high;
         cnt_ff     <= j_cnt;
         min_ff     <= j_min;
         max_ff     <= j_max;
         sat_ff     <= j_sat;
      end
      numf_ff <= numf_in;
      numd_ff <= numd_in;
      quof_ff <= quof_in;
      quod_ff <= quod_in;
      remf_ff <= remf_in;
      remd_ff <= remd_in;
      it_ff   <= it_in;
      freq_ff <= freq_in;
      duty_ff <= duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid          = valid_ff;
   assign rsp_frequency_hz    = freq_ff;
   assign rsp_duty_hundredths = duty_ff;
   assign rsp_min_sample      = min_ff;
   assign rsp_max_sample      = max_ff;
   assign rsp_overflow        = sat_ff;

endmodule

// ----- design/hysteresis_frequency_duty_meter.sv -----
// Hysteresis frequency and duty meter. Takes one sample per cycle while the queue
// has room; a capture result goes from the queue through the back end's idle,
// multiply, divide, finish and output states, and the bit-serial dividers take
// one quotient bit per cycle. Two finished captures queue between front and back;
// short captures sent back to back make the request side stall.
// Synchronous active-high reset clears counters, queue and output valid and
// restores thresholds to low 0 and high 65535.
module hysteresis_frequency_duty_meter #(
   parameter int unsigned MAX_SAMPLES = hfdm_pkg::MAX_SAMPLES_DEF,
   parameter int unsigned SAMPLE_BITS = hfdm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hfdm_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample[15:0], elapsed_us[47:16]
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // frequency_hz[34:0], duty_hundredths[48:35], min_sample[64:49], max_sample[80:65]
   output logic [hfdm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [hfdm_pkg::RSP_USER_W-1:0]     rsp_tuser,  // overflow[0]
   input  logic                                csr_we,
   input  logic [hfdm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hfdm_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import hfdm_pkg::*;

   localparam int unsigned CW    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned JOB_W = ELAPSED_W + 3 * CW + 2 * SAMP_W + 1;

   q_flags_type          q_flags;
   logic                 q_push, q_pop;
   logic [JOB_W-1:0]     q_wdata, q_rdata;
   logic [FREQ_W-1:0]    freq;
   logic [DUTY_W-1:0]    duty;
   logic [SAMP_W-1:0]    min_s, max_s;
   logic                 ovf;

   hfdm_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CW          (CW),
      .JOB_W       (JOB_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_sample     (req_tdata[SAMP_W-1:0]),
      .req_elapsed_us (req_tdata[SAMP_W +: ELAPSED_W]),
      .req_tlast      (req_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_flags        (q_flags),
      .q_push         (q_push),
      .q_wdata        (q_wdata)
   );

   hfdm_queue #(
      .JOB_W (JOB_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .flags (q_flags)
   );

   hfdm_back #(
      .CW    (CW),
      .JOB_W (JOB_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_flags             (q_flags),
      .q_rdata             (q_rdata),
      .q_pop               (q_pop),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_frequency_hz    (freq),
      .rsp_duty_hundredths (duty),
      .rsp_min_sample      (min_s),
      .rsp_max_sample      (max_s),
      .rsp_overflow        (ovf)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, max_s, min_s, duty, freq};
   assign rsp_tuser = ovf;

endmodule

// ----- design/hfdm_checker.sv -----
// Port-level checks for the hysteresis frequency and duty meter, bound to the top.
// Uses hfdm_pkg for the response field positions.
module hfdm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hfdm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [hfdm_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import hfdm_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DUTY_LSB +: DUTY_W] <= DUTY_SCALE)
      else $error("duty above 100 percent");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[MIN_LSB +: SAMP_W] <= rsp_tdata[MAX_LSB +: SAMP_W])
      else $error("min sample above max sample");

   // first cycle out of reset shows no response
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind hysteresis_frequency_duty_meter hfdm_checker u_hfdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
